### rtl/zcpd_pkg.sv
`default_nettype none
package zcpd_pkg;

    // data path width of the timestamps and estimates
    localparam int DATA_W = 32;

    // default sizes for the top level parameters
    localparam int RING_DEPTH_DEF = 9;
    localparam int WIN_LOG2P1_DEF = 3;

    // register reset values and limits
    localparam logic [15:0] GLITCH_RST = 16'd2000;
    localparam logic [15:0] STALE_RST  = 16'd15000;
    localparam logic [6:0]  INT_MAX    = 7'd99;
    localparam logic [8:0]  PHASE_ONE  = 9'd256;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_INTENSITY = 2'd0,
        CFG_GLITCH    = 2'd1,
        CFG_STALE     = 2'd2
    } t_cfg_reg;

    // operations of the shared add/subtract unit
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_E_CMP,
        ST_U_DIFF,
        ST_U_GACC,
        ST_U_GLIM,
        ST_U_STALE,
        ST_WALK,
        ST_S2,
        ST_GADD,
        ST_ORDER,
        ST_OFFSET,
        ST_MEAN,
        ST_F_READ,
        ST_F_BASE,
        ST_F_CMP,
        ST_F_ADJ,
        ST_F_WHEN,
        ST_F_CMP2,
        ST_F_ADJ2,
        ST_F_DELAY,
        ST_OUT
    } t_state;

    // firing phase per intensity step, in 1/256 of a half period
    localparam logic [7:0] PHASE_LUT [0:99] = '{
        8'd0,   8'd14,  8'd19,  8'd24,  8'd29,  8'd32,  8'd36,  8'd39,  8'd43,  8'd44,
        8'd48,  8'd49,  8'd53,  8'd54,  8'd58,  8'd60,  8'd61,  8'd63,  8'd65,  8'd66,
        8'd68,  8'd71,  8'd73,  8'd75,  8'd77,  8'd78,  8'd80,  8'd82,  8'd82,  8'd83,
        8'd85,  8'd87,  8'd88,  8'd90,  8'd92,  8'd94,  8'd95,  8'd97,  8'd97,  8'd99,
        8'd100, 8'd102, 8'd104, 8'd105, 8'd105, 8'd107, 8'd109, 8'd111, 8'd112, 8'd114,
        8'd114, 8'd116, 8'd117, 8'd119, 8'd121, 8'd122, 8'd124, 8'd124, 8'd126, 8'd128,
        8'd129, 8'd131, 8'd133, 8'd134, 8'd134, 8'd136, 8'd138, 8'd139, 8'd141, 8'd143,
        8'd145, 8'd146, 8'd148, 8'd150, 8'd151, 8'd153, 8'd155, 8'd156, 8'd158, 8'd160,
        8'd162, 8'd163, 8'd165, 8'd168, 8'd170, 8'd172, 8'd173, 8'd177, 8'd179, 8'd182,
        8'd184, 8'd187, 8'd190, 8'd194, 8'd197, 8'd202, 8'd207, 8'd214, 8'd223, 8'd255
    };

    function automatic logic [7:0] phase_lut(input logic [6:0] idx);
        logic [7:0] v;
        if (idx > INT_MAX) begin
            v = 8'd0;
        end else begin
            v = PHASE_LUT[idx];
        end
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/zcpd_ram.sv
`default_nettype none
module zcpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/zcpd_alu.sv
`default_nettype none
module zcpd_alu
    import zcpd_pkg::*;
(
    input  wire t_alu_op           i_op,
    input  wire logic [DATA_W-1:0] i_a,
    input  wire logic [DATA_W-1:0] i_b,
    output logic      [DATA_W-1:0] o_y,
    output logic                   o_carry
);

    logic [DATA_W-1:0] b_in;
    logic [DATA_W:0]   sum;

    // subtract as a plus inverted b plus one; carry low means a borrow
    assign b_in = (i_op == ALU_SUB) ? ~i_b : i_b;
    assign sum  = {1'b0, i_a} + {1'b0, b_in} + {{DATA_W{1'b0}}, (i_op == ALU_SUB)};

    assign o_y     = sum[DATA_W-1:0];
    assign o_carry = sum[DATA_W];

endmodule
`default_nettype wire

### rtl/zero_cross_phase_dimmer.sv
// Mains zero-cross tracker and triac firing planner. Each input word is either a detector
// edge (tuser low) or a fire-time query (tuser high) and gives exactly one result word. Edge
// timestamps live in a small ring memory; every add and subtract step goes through one shared
// 32-bit add/subtract unit under a sequencer, one step per cycle, and the block takes no new
// word until the result has been taken and the sequencer is back in idle. A full estimate
// update includes a ring walk that reads one stored timestamp per cycle. With intensity 0 the
// seven firing steps are skipped. Configuration writes are taken at any time but are meant to
// be done while no word is in flight.
`default_nettype none
module zero_cross_phase_dimmer
    import zcpd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int WIN_LOG2P1 = WIN_LOG2P1_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input words
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] timestamp, [32] level, [39:33] zero
    input  wire logic [39:0]  s_axis_tdata,
    // [0] action
    input  wire logic [0:0]   s_axis_tuser,
    // result words
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [0] edge_taken, [1] period_valid, [33:2] half_period, [65:34] detector_offset,
    // [66] fire_enabled, [98:67] fire_delay, [103:99] zero
    output logic      [103:0] m_axis_tdata,
    // configuration
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [15:0]  i_cfg_wdata
);

    localparam int PTR_W    = $clog2(RING_DEPTH);
    localparam int WARM_W   = $clog2(RING_DEPTH + 1);
    localparam int WIN_SH   = WIN_LOG2P1 - 1;
    localparam int WALK_LEN = 2 ** WIN_LOG2P1;
    localparam int CNT_W    = $clog2(WALK_LEN + 1);

    localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(RING_DEPTH - 1);
    localparam logic [WARM_W-1:0] DEPTH_WARM = WARM_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0]  WALK_END   = CNT_W'(WALK_LEN);

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] i);
        return (i == '0) ? LAST_PTR : i - PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
        return (i == LAST_PTR) ? '0 : i + PTR_W'(1);
    endfunction

    // state
    t_state              r_state, n_state;
    logic [DATA_W-1:0]   r_ts, n_ts;
    logic                r_lvl, n_lvl;
    logic                r_lvl_known, n_lvl_known;
    logic                r_lvl_val, n_lvl_val;
    logic                r_taken, n_taken;
    logic [PTR_W-1:0]    r_ptr, n_ptr;
    logic [WARM_W-1:0]   r_warm, n_warm;
    logic [DATA_W-1:0]   r_g, n_g;
    logic [DATA_W-1:0]   r_half, n_half;
    logic [DATA_W-1:0]   r_off, n_off;
    logic                r_est_vld, n_est_vld;
    logic [RING_DEPTH-1:0] r_vld, n_vld;
    logic                r_rd_vld;
    logic [DATA_W-1:0]   r_acc, n_acc;
    logic [DATA_W-1:0]   r_s1, n_s1;
    logic [DATA_W-1:0]   r_s2, n_s2;
    logic [DATA_W-1:0]   r_e0, n_e0;
    logic [PTR_W-1:0]    r_j, n_j;
    logic [CNT_W-1:0]    r_m, n_m;
    logic                r_flag, n_flag;
    logic [DATA_W-1:0]   r_frac, n_frac;

    // configuration registers
    logic [6:0]          r_int;
    logic [15:0]         r_glim;
    logic [15:0]         r_stale;

    // ring memory port
    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr;
    logic [PTR_W-1:0]    ram_raddr;
    logic [DATA_W-1:0]   ram_q;
    logic [DATA_W-1:0]   rd;

    // shared unit
    t_alu_op             alu_op;
    logic [DATA_W-1:0]   alu_a, alu_b, alu_y;
    logic                alu_c;

    // helpers
    logic                e_lt;
    logic [PTR_W-1:0]    e_np;
    logic [WARM_W-1:0]   e_warm;
    logic [DATA_W-1:0]   s1_sh, s2_sh;
    logic [8:0]          mul_k;
    logic [40:0]         prod;
    logic                ref_low;

    zcpd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_ts),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    zcpd_alu u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_y     (alu_y),
        .o_carry (alu_c)
    );

    // never-written ring slots read as zero
    assign rd = r_rd_vld ? ram_q : '0;

    // edge bookkeeping for the compare step
    assign e_lt   = ~alu_c;
    assign e_np   = ring_next(e_lt ? LAST_PTR : r_ptr);
    assign e_warm = e_lt ? DEPTH_WARM : r_warm;

    // window averages and firing fraction
    assign s1_sh   = r_s1 >> WIN_SH;
    assign s2_sh   = r_s2 >> WIN_SH;
    assign mul_k   = PHASE_ONE - {1'b0, phase_lut(r_int)};
    assign prod    = {32'd0, mul_k} * {9'd0, r_half};
    assign ref_low = r_lvl_known & ~r_lvl_val;

    // sequencer: next state, unit operands and data path updates
    always_comb begin
        n_state     = r_state;
        n_ts        = r_ts;
        n_lvl       = r_lvl;
        n_lvl_known = r_lvl_known;
        n_lvl_val   = r_lvl_val;
        n_taken     = r_taken;
        n_ptr       = r_ptr;
        n_warm      = r_warm;
        n_g         = r_g;
        n_half      = r_half;
        n_off       = r_off;
        n_est_vld   = r_est_vld;
        n_vld       = r_vld;
        n_acc       = r_acc;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_e0        = r_e0;
        n_j         = r_j;
        n_m         = r_m;
        n_flag      = r_flag;
        n_frac      = r_frac;
        alu_op      = ALU_ADD;
        alu_a       = r_acc;
        alu_b       = rd;
        ram_we      = 1'b0;
        ram_waddr   = e_np;
        ram_raddr   = r_ptr;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_ts    = s_axis_tdata[31:0];
                    n_lvl   = s_axis_tdata[32];
                    n_taken = ~s_axis_tuser[0] &
                              (~r_lvl_known | (s_axis_tdata[32] != r_lvl_val));
                    n_state = n_taken ? ST_E_CMP : ST_F_READ;
                end
            end
            // newest slot against the new time; store the edge
            ST_E_CMP: begin
                alu_op      = ALU_SUB;
                alu_a       = r_ts;
                alu_b       = rd;
                ram_we      = 1'b1;
                ram_raddr   = ring_prev(e_np);
                n_vld       = (e_lt ? '0 : r_vld) | (RING_DEPTH'(1) << e_np);
                n_ptr       = e_np;
                n_lvl_known = 1'b1;
                n_lvl_val   = r_lvl;
                if (e_lt) begin
                    n_g       = '0;
                    n_est_vld = 1'b0;
                end
                if (e_warm != '0) begin
                    n_warm  = e_warm - WARM_W'(1);
                    n_state = ST_F_READ;
                end else begin
                    n_state = ST_U_DIFF;
                end
            end
            ST_U_DIFF: begin
                alu_op  = ALU_SUB;
                alu_a   = r_ts;
                alu_b   = rd;
                n_acc   = alu_y;
                n_state = ST_U_GACC;
            end
            ST_U_GACC: begin
                alu_b   = r_g;
                n_acc   = alu_y;
                n_state = ST_U_GLIM;
            end
            // short interval: merge as glitch
            ST_U_GLIM: begin
                alu_op = ALU_SUB;
                alu_b  = {16'd0, r_glim};
                if (!alu_c) begin
                    n_g     = r_acc;
                    n_ptr   = ring_prev(r_ptr);
                    n_state = ST_F_READ;
                end else begin
                    n_state = ST_U_STALE;
                end
            end
            // long interval drops the glitch time; start the ring walk
            ST_U_STALE: begin
                alu_op    = ALU_SUB;
                alu_a     = {16'd0, r_stale};
                alu_b     = r_acc;
                ram_raddr = r_ptr;
                if (!alu_c) begin
                    n_g = '0;
                end
                n_j     = ring_prev(r_ptr);
                n_m     = '0;
                n_state = ST_WALK;
            end
            // alternating sum over the window, one slot a cycle
            ST_WALK: begin
                ram_raddr = r_j;
                n_j       = ring_prev(r_j);
                n_m       = r_m + CNT_W'(1);
                if (r_m == '0) begin
                    n_s1 = rd;
                    n_e0 = rd;
                end else if (r_m == WALK_END) begin
                    alu_op  = ALU_SUB;
                    alu_a   = r_e0;
                    n_e0    = alu_y;
                    n_state = ST_S2;
                end else begin
                    alu_op = r_m[0] ? ALU_SUB : ALU_ADD;
                    alu_a  = r_s1;
                    n_s1   = alu_y;
                end
            end
            // second sum from the span of the window less the first
            ST_S2: begin
                alu_op  = ALU_SUB;
                alu_a   = r_e0;
                alu_b   = r_s1;
                n_s2    = alu_y;
                n_state = ST_GADD;
            end
            ST_GADD: begin
                alu_a   = r_s1;
                alu_b   = r_g;
                n_s1    = alu_y;
                n_g     = '0;
                n_state = ST_ORDER;
            end
            // order the two averages, smaller first
            ST_ORDER: begin
                alu_op = ALU_SUB;
                alu_a  = s2_sh;
                alu_b  = s1_sh;
                if (!alu_c) begin
                    n_s1 = r_s2;
                    n_s2 = r_s1;
                end
                n_state = ST_OFFSET;
            end
            ST_OFFSET: begin
                alu_op  = ALU_SUB;
                alu_a   = s2_sh;
                alu_b   = s1_sh;
                n_off   = alu_y;
                n_state = ST_MEAN;
            end
            ST_MEAN: begin
                alu_a     = s1_sh;
                alu_b     = s2_sh;
                n_half    = {alu_c, alu_y[DATA_W-1:1]};
                n_est_vld = 1'b1;
                n_state   = ST_F_READ;
            end
            // reference edge read and firing fraction
            ST_F_READ: begin
                ram_raddr = ref_low ? ring_prev(r_ptr) : r_ptr;
                n_frac    = prod[39:8];
                if (r_int == '0) begin
                    n_acc   = '0;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_F_BASE;
                end
            end
            ST_F_BASE: begin
                alu_a   = rd;
                alu_b   = ref_low ? r_half : '0;
                n_acc   = alu_y;
                n_state = ST_F_CMP;
            end
            ST_F_CMP: begin
                alu_op  = ALU_SUB;
                alu_a   = r_ts;
                alu_b   = r_acc;
                n_flag  = ~alu_c;
                n_state = ST_F_ADJ;
            end
            ST_F_ADJ: begin
                alu_op  = ALU_SUB;
                alu_b   = r_flag ? r_half : '0;
                n_acc   = alu_y;
                n_state = ST_F_WHEN;
            end
            ST_F_WHEN: begin
                alu_a   = r_frac;
                alu_b   = r_acc;
                n_acc   = alu_y;
                n_state = ST_F_CMP2;
            end
            ST_F_CMP2: begin
                alu_op  = ALU_SUB;
                alu_b   = r_ts;
                n_flag  = ~alu_c;
                n_state = ST_F_ADJ2;
            end
            ST_F_ADJ2: begin
                alu_b   = r_flag ? r_half : '0;
                n_acc   = alu_y;
                n_state = ST_F_DELAY;
            end
            ST_F_DELAY: begin
                alu_op  = ALU_SUB;
                alu_b   = r_ts;
                n_acc   = alu_y;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // tracker state that reset defines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_known <= 1'b0;
            r_lvl_val   <= 1'b0;
            r_ptr       <= '0;
            r_warm      <= DEPTH_WARM;
            r_g         <= '0;
            r_half      <= '0;
            r_off       <= '0;
            r_est_vld   <= 1'b0;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_lvl_known <= n_lvl_known;
            r_lvl_val   <= n_lvl_val;
            r_ptr       <= n_ptr;
            r_warm      <= n_warm;
            r_g         <= n_g;
            r_half      <= n_half;
            r_off       <= n_off;
            r_est_vld   <= n_est_vld;
            r_vld       <= n_vld;
            r_rd_vld    <= r_vld[ram_raddr];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_ts    <= n_ts;
        r_lvl   <= n_lvl;
        r_taken <= n_taken;
        r_acc   <= n_acc;
        r_s1    <= n_s1;
        r_s2    <= n_s2;
        r_e0    <= n_e0;
        r_j     <= n_j;
        r_m     <= n_m;
        r_flag  <= n_flag;
        r_frac  <= n_frac;
    end

    // configuration writes, intensity saturates at the top step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int   <= '0;
            r_glim  <= GLITCH_RST;
            r_stale <= STALE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_INTENSITY: begin
                    r_int <= (i_cfg_wdata[6:0] > INT_MAX) ? INT_MAX : i_cfg_wdata[6:0];
                end
                CFG_GLITCH: begin
                    r_glim <= i_cfg_wdata;
                end
                CFG_STALE: begin
                    r_stale <= i_cfg_wdata;
                end
                default: begin
                    r_int <= r_int;
                end
            endcase
        end
    end

    // result word
    assign m_axis_tdata = {5'd0, r_acc, (r_int != '0), r_off, r_half, r_est_vld, r_taken};

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import zcpd_pkg::*;

    // block sizes as built here
    localparam int RING_N     = 9;
    localparam int WIN_LOG2P1 = 3;
    localparam int WIN_SHIFT  = WIN_LOG2P1 - 1;
    localparam int WIN_PAIRS  = 1 << WIN_SHIFT;

    // run control
    localparam int SETTLE_CYCLES  = 64;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int SEGMENT_WORDS  = 150;
    localparam int SEGMENTS       = 4;
    localparam int TIMEOUT_NS     = 10_000_000;

    // word kinds and level codes
    localparam logic       ACT_EDGE      = 1'b0;
    localparam logic       ACT_QUERY     = 1'b1;
    localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;
    localparam logic [6:0] DIM_TOP       = 7'd99;

    // firing phase per dimmer step, in 1/256 of a half period
    localparam logic [7:0] FIRE_PHASE [0:99] = '{
        8'd0,   8'd14,  8'd19,  8'd24,  8'd29,  8'd32,  8'd36,  8'd39,  8'd43,  8'd44,
        8'd48,  8'd49,  8'd53,  8'd54,  8'd58,  8'd60,  8'd61,  8'd63,  8'd65,  8'd66,
        8'd68,  8'd71,  8'd73,  8'd75,  8'd77,  8'd78,  8'd80,  8'd82,  8'd82,  8'd83,
        8'd85,  8'd87,  8'd88,  8'd90,  8'd92,  8'd94,  8'd95,  8'd97,  8'd97,  8'd99,
        8'd100, 8'd102, 8'd104, 8'd105, 8'd105, 8'd107, 8'd109, 8'd111, 8'd112, 8'd114,
        8'd114, 8'd116, 8'd117, 8'd119, 8'd121, 8'd122, 8'd124, 8'd124, 8'd126, 8'd128,
        8'd129, 8'd131, 8'd133, 8'd134, 8'd134, 8'd136, 8'd138, 8'd139, 8'd141, 8'd143,
        8'd145, 8'd146, 8'd148, 8'd150, 8'd151, 8'd153, 8'd155, 8'd156, 8'd158, 8'd160,
        8'd162, 8'd163, 8'd165, 8'd168, 8'd170, 8'd172, 8'd173, 8'd177, 8'd179, 8'd182,
        8'd184, 8'd187, 8'd190, 8'd194, 8'd197, 8'd202, 8'd207, 8'd214, 8'd223, 8'd255
    };

    typedef struct packed {
        logic        edge_taken;
        logic        period_valid;
        logic [31:0] half_period;
        logic [31:0] detector_offset;
        logic        fire_enabled;
        logic [31:0] fire_delay;
    } dimmer_result_t;

    // dut ports
    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [39:0]   s_axis_tdata;    // [31:0] timestamp, [32] level, [39:33] zero
    logic [0:0]    s_axis_tuser;    // [0] action
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // [0] edge_taken, [1] period_valid, [33:2] half_period, [65:34] detector_offset,
    // [66] fire_enabled, [98:67] fire_delay, [103:99] zero
    logic [103:0]  m_axis_tdata;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_addr;
    logic [15:0]   i_cfg_wdata;

    // predictor state, mirrors the tracker after reset
    logic [31:0]   ring_ts [0:RING_N-1] = '{default: 32'd0};
    int unsigned   wr_slot    = 0;
    int            warm_cnt   = RING_N;
    logic [1:0]    held_level = LEVEL_UNKNOWN;
    logic [31:0]   glitch_sum = 32'd0;
    logic [31:0]   half_est   = 32'd0;
    logic [31:0]   skew_est   = 32'd0;
    logic          est_ok     = 1'b0;
    logic [6:0]    dim_level  = 7'd0;
    logic [15:0]   glitch_lim = 16'd2000;
    logic [15:0]   stale_lim  = 16'd15000;

    dimmer_result_t pending_dimmer_results [$];
    dimmer_result_t want_now;

    // stimulus state: simulated mains timeline
    logic [31:0]   mains_now = 32'd0;
    logic          mains_lvl = 1'b0;
    logic [31:0]   mains_half_us;
    logic [31:0]   mains_skew_us;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    // tallies
    int            fail_count       = 0;
    int            words_sent       = 0;
    int            queries_sent     = 0;
    int            edges_taken      = 0;
    int            estimate_updates = 0;
    int            glitch_merges    = 0;
    int            ring_clears      = 0;
    int            cfg_writes       = 0;

    zero_cross_phase_dimmer #(
        .RING_DEPTH (RING_N),
        .WIN_LOG2P1 (WIN_LOG2P1)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ring index stepping, wraps at the ring depth
    function automatic int unsigned slot_before(input int unsigned i);
        return (i == 0 || i >= RING_N) ? RING_N - 1 : i - 1;
    endfunction

    function automatic int unsigned slot_after(input int unsigned i);
        return (i >= RING_N - 1) ? 0 : i + 1;
    endfunction

    // glitch merge or alternate-interval averages after a stored edge
    function automatic void refresh_estimates();
        int unsigned p;
        int unsigned i;
        int          k;
        logic [31:0] d;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] t;
        logic [32:0] pair_sum;
        p = wr_slot;
        d = ring_ts[p] - ring_ts[slot_before(p)] + glitch_sum;
        if (d < {16'd0, glitch_lim}) begin
            glitch_sum = d;
            wr_slot = slot_before(p);
            glitch_merges++;
            return;
        end
        if (d > {16'd0, stale_lim}) begin
            glitch_sum = 32'd0;
        end
        s1 = 32'd0;
        i = p;
        for (k = 0; k < WIN_PAIRS; k++) begin
            s1 = s1 + ring_ts[i] - ring_ts[slot_before(i)];
            i = slot_before(slot_before(i));
        end
        s1 = s1 + glitch_sum;
        glitch_sum = 32'd0;
        s2 = 32'd0;
        i = p;
        for (k = 0; k < WIN_PAIRS; k++) begin
            i = slot_before(i);
            s2 = s2 + ring_ts[i];
            i = slot_before(i);
            s2 = s2 - ring_ts[i];
        end
        a = s1 >> WIN_SHIFT;
        b = s2 >> WIN_SHIFT;
        if (a > b) begin
            t = a;
            a = b;
            b = t;
        end
        skew_est = b - a;
        pair_sum = {1'b0, a} + {1'b0, b};
        half_est = pair_sum[32:1];
        est_ok = 1'b1;
        estimate_updates++;
    endfunction

    // time from now to the next planned firing, modulo 2^32
    function automatic logic [31:0] fire_delay_from(input logic [31:0] now_us);
        logic [31:0] half;
        logic [31:0] t0;
        logic [31:0] fire_at;
        logic [8:0]  share;
        logic [63:0] prod;
        half = half_est;
        if (held_level != 2'd0) begin
            t0 = ring_ts[wr_slot];
        end else begin
            t0 = ring_ts[slot_before(wr_slot)] + half;
        end
        if (t0 > now_us) begin
            t0 = t0 - half;
        end
        share = 9'd256 - {1'b0, FIRE_PHASE[dim_level]};
        prod = {55'd0, share} * {32'd0, half};
        fire_at = prod[39:8] + t0;
        if (fire_at < now_us) begin
            fire_at = fire_at + half;
        end
        return fire_at - now_us;
    endfunction

    // predicted result of one accepted word, queued for the checker
    function automatic void compute_dimmer_result(input logic act, input logic [31:0] ts,
                                                  input logic lvl);
        dimmer_result_t r;
        int             j;
        r.edge_taken = 1'b0;
        if (act == ACT_QUERY) begin
            queries_sent++;
        end
        if (act == ACT_EDGE && {1'b0, lvl} != held_level) begin
            r.edge_taken = 1'b1;
            edges_taken++;
            // time went backwards: start over with an empty ring
            if (ts < ring_ts[wr_slot]) begin
                for (j = 0; j < RING_N; j++) begin
                    ring_ts[j] = 32'd0;
                end
                wr_slot = RING_N - 1;
                warm_cnt = RING_N;
                glitch_sum = 32'd0;
                est_ok = 1'b0;
                ring_clears++;
            end
            wr_slot = slot_after(wr_slot);
            ring_ts[wr_slot] = ts;
            held_level = {1'b0, lvl};
            if (warm_cnt > 0) begin
                warm_cnt--;
            end else begin
                refresh_estimates();
            end
        end
        r.period_valid = est_ok;
        r.half_period = half_est;
        r.detector_offset = skew_est;
        r.fire_enabled = (dim_level != 7'd0);
        r.fire_delay = (dim_level != 7'd0) ? fire_delay_from(ts) : 32'd0;
        pending_dimmer_results.push_back(r);
        words_sent++;
    endfunction

    // send one word, with random idle cycles before it
    task automatic send_word(input logic act, input logic [31:0] ts, input logic lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, lvl, ts};
        s_axis_tuser <= act;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) begin
            @(posedge i_clk);
        end
        compute_dimmer_result(act, ts, lvl);
    endtask

    // next detector edge on the mains timeline
    task automatic step_edge(input logic [31:0] gap);
        mains_now = mains_now + gap;
        mains_lvl = ~mains_lvl;
        send_word(ACT_EDGE, mains_now, mains_lvl);
    endtask

    // hold the sender until every expected word is back and the block is quiet
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_dimmer_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, only while idle
    task automatic write_reg(input t_cfg_reg idx, input logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_INTENSITY: dim_level = (value[6:0] > DIM_TOP) ? DIM_TOP : value[6:0];
            CFG_GLITCH:    glitch_lim = value;
            CFG_STALE:     stale_lim = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // queries straight out of reset, then the very first edge
    task automatic test_reset_state();
        send_word(ACT_QUERY, 32'h0000_0000, 1'b0);
        wait_idle();
        write_reg(CFG_INTENSITY, 16'd99);
        send_word(ACT_QUERY, 32'hFFFF_FFFF, 1'b1);
        mains_now = 32'd0;
        mains_lvl = 1'b0;
        send_word(ACT_EDGE, mains_now, mains_lvl);
    endtask

    // warm-up runs out, then uneven half cycles give an offset
    task automatic test_warmup_and_estimates();
        int j;
        wait_idle();
        write_reg(CFG_INTENSITY, 16'd50);
        for (j = 0; j < 9; j++) begin
            step_edge(j[0] ? 32'd10300 : 32'd9700);
            if (j == 4) begin
                // repeated level is ignored
                send_word(ACT_EDGE, mains_now + 32'd500, mains_lvl);
            end
        end
        send_word(ACT_QUERY, mains_now + 32'd4000, 1'b0);
    endtask

    // short spikes merged, then one stale interval drops the spike time
    task automatic test_glitch_and_stale();
        step_edge(32'd9800);
        step_edge(32'd350);
        step_edge(32'd9700);
        step_edge(32'd400);
        step_edge(32'd21000);
    endtask

    // limits at both ends and a saturating dimmer level
    task automatic test_register_extremes();
        wait_idle();
        write_reg(CFG_INTENSITY, 16'h007F);
        write_reg(CFG_GLITCH, 16'hFFFF);
        write_reg(CFG_STALE, 16'h0000);
        step_edge(32'd10000);
        step_edge(32'd10000);
        send_word(ACT_QUERY, mains_now + 32'd2500, 1'b1);
        wait_idle();
        write_reg(CFG_GLITCH, 16'h0000);
        write_reg(CFG_STALE, 16'hFFFF);
        write_reg(CFG_INTENSITY, 16'hFF81);
        step_edge(32'd10100);
        step_edge(32'd9900);
    endtask

    // edges older than the newest stored one clear the ring
    task automatic test_time_backwards();
        wait_idle();
        write_reg(CFG_INTENSITY, 16'd0);
        mains_now = mains_now - 32'd5;
        mains_lvl = ~mains_lvl;
        send_word(ACT_EDGE, mains_now, mains_lvl);
        mains_now = 32'hFFFF_FFFF;
        mains_lvl = ~mains_lvl;
        send_word(ACT_EDGE, mains_now, mains_lvl);
        step_edge(32'd1);
    endtask

    // mostly regular mains with spikes, gaps, noise and queries, three idling phases
    task automatic test_random_traffic();
        int          phase;
        int          seg;
        int          w;
        int          pick;
        logic [15:0] val;
        logic [31:0] q_ts;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (seg = 0; seg < SEGMENTS; seg++) begin
                wait_idle();
                // new register setting per segment, extremes included
                case ($urandom_range(9))
                    0:       val = 16'd0;
                    1:       val = 16'd99;
                    2:       val = 16'($urandom_range(100, 127));
                    3:       val = 16'($urandom);
                    default: val = 16'($urandom_range(1, 98));
                endcase
                write_reg(CFG_INTENSITY, val);
                case ($urandom_range(9))
                    0:       val = 16'd0;
                    1:       val = 16'hFFFF;
                    2:       val = 16'($urandom);
                    default: val = 16'($urandom_range(500, 3000));
                endcase
                write_reg(CFG_GLITCH, val);
                case ($urandom_range(9))
                    0:       val = 16'd0;
                    1:       val = 16'hFFFF;
                    2:       val = 16'($urandom);
                    default: val = 16'($urandom_range(11000, 20000));
                endcase
                write_reg(CFG_STALE, val);
                mains_half_us = $urandom_range(8000, 12000);
                mains_skew_us = $urandom_range(0, 1500);
                // sometimes run across the timestamp wrap
                if ($urandom_range(3) == 0) begin
                    mains_now = 32'hFFFF_FFFF - $urandom_range(0, 300000);
                end
                for (w = 0; w < SEGMENT_WORDS; w++) begin
                    pick = $urandom_range(99);
                    if (pick < 50) begin
                        step_edge((mains_lvl ? mains_half_us + mains_skew_us
                                             : mains_half_us - mains_skew_us)
                                  + $urandom_range(0, 150));
                    end else if (pick < 62) begin
                        step_edge($urandom_range(1, 2500));
                    end else if (pick < 68) begin
                        step_edge($urandom_range(15000, 60000));
                    end else if (pick < 84) begin
                        case ($urandom_range(5))
                            0:       q_ts = $urandom;
                            1:       q_ts = mains_now - $urandom_range(0, 20000);
                            default: q_ts = mains_now + $urandom_range(0, 25000);
                        endcase
                        send_word(ACT_QUERY, q_ts, 1'($urandom_range(1)));
                    end else if (pick < 90) begin
                        send_word(ACT_EDGE, mains_now + $urandom_range(0, 3000), mains_lvl);
                    end else if (pick < 95) begin
                        mains_now = $urandom;
                        mains_lvl = 1'($urandom_range(1));
                        send_word(ACT_EDGE, mains_now, mains_lvl);
                    end else begin
                        mains_now = mains_now - $urandom_range(1, 50000);
                        mains_lvl = ~mains_lvl;
                        send_word(ACT_EDGE, mains_now, mains_lvl);
                    end
                end
            end
        end
    endtask

    // result sink with random stalls
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_dimmer_results.size() == 0) begin
                $error("result word with nothing expected: %h", m_axis_tdata);
                fail_count++;
            end else begin
                want_now = pending_dimmer_results.pop_front();
                if (m_axis_tdata[0] !== want_now.edge_taken) begin
                    $error("edge_taken: expected %0d, got %0d",
                           want_now.edge_taken, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tdata[1] !== want_now.period_valid) begin
                    $error("period_valid: expected %0d, got %0d",
                           want_now.period_valid, m_axis_tdata[1]);
                    fail_count++;
                end
                if (m_axis_tdata[33:2] !== want_now.half_period) begin
                    $error("half_period: expected %0d, got %0d",
                           want_now.half_period, m_axis_tdata[33:2]);
                    fail_count++;
                end
                if (m_axis_tdata[65:34] !== want_now.detector_offset) begin
                    $error("detector_offset: expected %0d, got %0d",
                           want_now.detector_offset, m_axis_tdata[65:34]);
                    fail_count++;
                end
                if (m_axis_tdata[66] !== want_now.fire_enabled) begin
                    $error("fire_enabled: expected %0d, got %0d",
                           want_now.fire_enabled, m_axis_tdata[66]);
                    fail_count++;
                end
                if (m_axis_tdata[98:67] !== want_now.fire_delay) begin
                    $error("fire_delay: expected %0d, got %0d",
                           want_now.fire_delay, m_axis_tdata[98:67]);
                    fail_count++;
                end
            end
        end
    end

    // test sequence
    initial begin
        int guard;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 40'd0;
        s_axis_tuser <= ACT_EDGE;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= CFG_INTENSITY;
        i_cfg_wdata <= 16'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_warmup_and_estimates();
        test_glitch_and_stale();
        test_register_extremes();
        test_time_backwards();
        test_random_traffic();

        // let the last words come back, then a quiet tail
        s_axis_tvalid <= 1'b0;
        for (guard = 0; guard < DRAIN_LIMIT && pending_dimmer_results.size() != 0; guard++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_dimmer_results.size() != 0) begin
            $error("%0d expected result words never arrived", pending_dimmer_results.size());
            fail_count++;
        end

        $display("covered %0d words: %0d edges stored, %0d time queries, %0d estimate updates",
                 words_sent, edges_taken, queries_sent, estimate_updates);
        $display("  with %0d merged spikes, %0d ring restarts, %0d register writes",
                 glitch_merges, ring_clears, cfg_writes);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
